>>> design/cllm_pkg.sv
// shared types and codes for the cursor linked list manager
// no dependencies
`default_nettype none
package cllm_pkg;

   localparam int NODE_W = 6;
   localparam int NO_W   = 32;
   localparam int NAME_W = 64;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_REAR  = 3'd3,
      OP_REM_CUR   = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_CLEAR     = 3'd6,
      OP_READ_CUR  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STS_OK    = 3'd0,
      STS_EMPTY = 3'd1,
      STS_FULL  = 3'd2,
      STS_MISS  = 3'd3,
      STS_NOCUR = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TAKE,
      S_PLACE,
      S_TAIL_WALK,
      S_TAIL_LINK,
      S_POP_FRONT,
      S_REAR_FIRST,
      S_REAR_WALK,
      S_CUR_WALK,
      S_CUR_UNLINK,
      S_SEARCH,
      S_CLEAR,
      S_FETCH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [31:0]  mbr_num;
      logic [NAME_W-1:0]   mbr_label;
      logic                match_by_name;
   } req_word_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [NODE_W-1:0]   node_index;
      logic signed [31:0]  cur_no;
      logic [NAME_W-1:0]   cur_name;
      logic                cur_valid;
   } rsp_word_type;

   // equal up to and including the first zero byte, or over the first nbytes (at most 8) bytes
   function automatic logic names_equal(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b,
                                        input int nbytes);
      logic eq;
      logic done;
      eq   = 1'b1;
      done = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (i < nbytes && !done) begin
            if (a[8*i +: 8] != b[8*i +: 8]) begin
               eq   = 1'b0;
               done = 1'b1;
            end else if (a[8*i +: 8] == 8'd0) begin
               done = 1'b1;
            end
         end
      end
      return eq;
   endfunction

endpackage
`default_nettype wire

>>> design/cllm_chan_if.sv
// valid/ready channel carrying one word of a given type
// depends on nothing; word types come from cllm_pkg at instantiation
`default_nettype none
interface cllm_chan_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/cursor_linked_list_manager.sv
// cursor linked list manager: a sequencer over link, free-list and record memories
// a request is accepted in idle and decoded in dispatch; inserts take a slot off the free list
//   (take) or past the high-water mark, then write it (place); walks follow links node by node
// all operations end in fetch, then finish, which waits on a stalled output; one word at a time
// reset: synchronous, empties the list, free list and cursor; memories keep their contents
// depends on cllm_pkg and cllm_chan_if
`default_nettype none
module cursor_linked_list_manager #(
   parameter int CAPACITY   = 64,
   parameter int NAME_BYTES = 8
) (
   input wire logic clock,
   input wire logic reset,
   cllm_chan_if.sink   req_ch,
   cllm_chan_if.source rsp_ch
);
   import cllm_pkg::*;

   localparam int SW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int NW = 8 * NAME_BYTES;

   typedef logic [SW-1:0] slot_type;

   // storage
   slot_type          next_link   [CAPACITY];
   slot_type          free_link   [CAPACITY];
   logic [NO_W-1:0]   node_number [CAPACITY];
   logic [NW-1:0]     node_name   [CAPACITY];

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [NO_W-1:0] no_ff, no_in;
   logic [NW-1:0]   name_ff, name_in;
   logic by_name_ff, by_name_in;
   slot_type head_ff, head_in, cur_ff, cur_in, hw_ff, hw_in, fhead_ff, fhead_in;
   slot_type slot_ff, slot_in, walk_ff, walk_in, prev_ff, prev_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   // memory ports
   slot_type link_raddr, link_rdata_ff, link_waddr, link_wdata;
   logic link_we;
   slot_type free_raddr, free_rdata_ff, free_waddr, free_wdata;
   logic free_we;
   slot_type data_raddr, data_waddr;
   logic data_we;
   logic [NO_W-1:0] num_rdata_ff;
   logic [NW-1:0]   name_rdata_ff;

   logic [SW:0] hw_next;
   logic        hit;

   always_ff @(posedge clock) begin
      if (link_we) next_link[link_waddr] <= link_wdata;
      link_rdata_ff <= next_link[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (free_we) free_link[free_waddr] <= free_wdata;
      free_rdata_ff <= free_link[free_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         node_number[data_waddr] <= no_ff;
         node_name[data_waddr]   <= name_ff;
      end
      num_rdata_ff  <= node_number[data_raddr];
      name_rdata_ff <= node_name[data_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         cur_ff       <= '0;
         hw_ff        <= '0;
         fhead_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         hw_ff        <= hw_in;
         fhead_ff     <= fhead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      no_ff      <= no_in;
      name_ff    <= name_in;
      by_name_ff <= by_name_in;
      slot_ff    <= slot_in;
      walk_ff    <= walk_in;
      prev_ff    <= prev_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign hw_next = {1'b0, hw_ff} + {{SW{1'b0}}, 1'b1};
   assign hit = by_name_ff ?
      names_equal(NAME_W'(name_rdata_ff), NAME_W'(name_ff), NAME_BYTES) :
      (num_rdata_ff == no_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      no_in        = no_ff;
      name_in      = name_ff;
      by_name_in   = by_name_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      hw_in        = hw_ff;
      fhead_in     = fhead_ff;
      slot_in      = slot_ff;
      walk_in      = walk_ff;
      prev_in      = prev_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      link_raddr   = walk_ff;
      link_we      = 1'b0;
      link_waddr   = slot_ff;
      link_wdata   = '0;
      free_raddr   = fhead_ff;
      free_we      = 1'b0;
      free_waddr   = head_ff;
      free_wdata   = fhead_ff;
      data_raddr   = cur_ff;
      data_we      = 1'b0;
      data_waddr   = slot_ff;
      req_ch.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in      = op_type'(req_ch.data.op);
               no_in      = req_ch.data.mbr_num;
               name_in    = req_ch.data.mbr_label[NW-1:0];
               by_name_in = req_ch.data.match_by_name;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = STS_OK;
            state_in  = S_FETCH;
            link_raddr = head_ff;
            data_raddr = head_ff;
            case (op_ff)
               OP_INS_FRONT, OP_INS_REAR: begin
                  if (fhead_ff != '0) begin
                     slot_in  = fhead_ff;
                     state_in = S_TAKE;
                  end else if (hw_next >= (SW+1)'(CAPACITY)) begin
                     status_in = STS_FULL;
                  end else begin
                     slot_in  = hw_next[SW-1:0];
                     hw_in    = hw_next[SW-1:0];
                     state_in = S_PLACE;
                  end
               end
               OP_REM_FRONT: begin
                  if (head_ff == '0) status_in = STS_EMPTY;
                  else state_in = S_POP_FRONT;
               end
               OP_REM_REAR: begin
                  if (head_ff == '0) status_in = STS_EMPTY;
                  else state_in = S_REAR_FIRST;
               end
               OP_REM_CUR: begin
                  if (cur_ff == '0) begin
                     status_in = STS_NOCUR;
                  end else if (cur_ff == head_ff) begin
                     state_in = S_POP_FRONT;
                  end else begin
                     walk_in  = head_ff;
                     state_in = S_CUR_WALK;
                  end
               end
               OP_SEARCH: begin
                  if (head_ff == '0) begin
                     status_in = STS_EMPTY;
                  end else begin
                     walk_in  = head_ff;
                     state_in = S_SEARCH;
                  end
               end
               OP_CLEAR: begin
                  if (head_ff == '0) status_in = STS_EMPTY;
                  else state_in = S_CLEAR;
               end
               default: begin
                  if (cur_ff == '0) status_in = STS_NOCUR;
               end
            endcase
         end
         S_TAKE: begin
            fhead_in = free_rdata_ff;
            state_in = S_PLACE;
         end
         S_PLACE: begin
            data_we = 1'b1;
            if (op_ff == OP_INS_FRONT || head_ff == '0) begin
               link_we    = 1'b1;
               link_wdata = head_ff;
               head_in    = slot_ff;
               cur_in     = slot_ff;
               state_in   = S_FETCH;
            end else begin
               walk_in    = head_ff;
               link_raddr = head_ff;
               state_in   = S_TAIL_WALK;
            end
         end
         S_TAIL_WALK: begin
            if (link_rdata_ff == '0) begin
               // new tail gets a null link, then the old tail points at it
               link_we  = 1'b1;
               state_in = S_TAIL_LINK;
            end else begin
               walk_in    = link_rdata_ff;
               link_raddr = link_rdata_ff;
            end
         end
         S_TAIL_LINK: begin
            link_we    = 1'b1;
            link_waddr = walk_ff;
            link_wdata = slot_ff;
            cur_in     = slot_ff;
            state_in   = S_FETCH;
         end
         S_POP_FRONT: begin
            free_we  = 1'b1;
            fhead_in = head_ff;
            head_in  = link_rdata_ff;
            cur_in   = link_rdata_ff;
            state_in = S_FETCH;
         end
         S_REAR_FIRST: begin
            if (link_rdata_ff == '0) begin
               free_we  = 1'b1;
               fhead_in = head_ff;
               head_in  = '0;
               cur_in   = '0;
               state_in = S_FETCH;
            end else begin
               prev_in    = head_ff;
               walk_in    = link_rdata_ff;
               link_raddr = link_rdata_ff;
               state_in   = S_REAR_WALK;
            end
         end
         S_REAR_WALK: begin
            if (link_rdata_ff == '0) begin
               link_we    = 1'b1;
               link_waddr = prev_ff;
               free_we    = 1'b1;
               free_waddr = walk_ff;
               fhead_in   = walk_ff;
               cur_in     = prev_ff;
               state_in   = S_FETCH;
            end else begin
               prev_in    = walk_ff;
               walk_in    = link_rdata_ff;
               link_raddr = link_rdata_ff;
            end
         end
         S_CUR_WALK: begin
            if (link_rdata_ff == cur_ff) begin
               link_raddr = cur_ff;
               state_in   = S_CUR_UNLINK;
            end else if (link_rdata_ff == '0) begin
               // cursor is not on the list
               status_in = STS_NOCUR;
               state_in  = S_FETCH;
            end else begin
               walk_in    = link_rdata_ff;
               link_raddr = link_rdata_ff;
            end
         end
         S_CUR_UNLINK: begin
            link_we    = 1'b1;
            link_waddr = walk_ff;
            link_wdata = link_rdata_ff;
            free_we    = 1'b1;
            free_waddr = cur_ff;
            fhead_in   = cur_ff;
            cur_in     = walk_ff;
            state_in   = S_FETCH;
         end
         S_SEARCH: begin
            if (hit) begin
               cur_in   = walk_ff;
               state_in = S_FETCH;
            end else if (link_rdata_ff == '0) begin
               status_in = STS_MISS;
               state_in  = S_FETCH;
            end else begin
               walk_in    = link_rdata_ff;
               link_raddr = link_rdata_ff;
               data_raddr = link_rdata_ff;
            end
         end
         S_CLEAR: begin
            free_we    = 1'b1;
            fhead_in   = head_ff;
            head_in    = link_rdata_ff;
            link_raddr = link_rdata_ff;
            if (link_rdata_ff == '0) begin
               cur_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.node_index = NODE_W'(cur_ff);
               rsp_in.cur_valid  = (cur_ff != '0);
               rsp_in.cur_no     = (cur_ff != '0) ? num_rdata_ff : '0;
               rsp_in.cur_name   = (cur_ff != '0) ? NAME_W'(name_rdata_ff) : '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

endmodule
`default_nettype wire
